[rtl/trw_l1_message_update_top_macros.svh]
// assertion macros for the message update block
`ifndef TRW_L1_MESSAGE_UPDATE_TOP_MACROS_SVH
`define TRW_L1_MESSAGE_UPDATE_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define TRWL1_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("trwl1 check failed");
`define TRWL1_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("trwl1 check failed");
`else
`define TRWL1_ASSERT(label, clk, rst, prop)
`define TRWL1_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/trwl1_pkg.sv]
package trwl1_pkg;

   localparam int NUM_LABELS = 16;
   localparam int LBL_W      = $clog2(NUM_LABELS);
   localparam int CNT_W      = $clog2(NUM_LABELS + 1);
   localparam int QDEPTH     = 4;
   localparam int QPTR_W     = $clog2(QDEPTH);
   localparam int QCNT_W     = $clog2(QDEPTH + 1);

   localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] NEG_MIN = 24'sh800000;

   typedef logic [1:0] csr_index_type;
   localparam csr_index_type CSR_SMOOTH_GAIN = 2'd0;
   localparam csr_index_type CSR_TRUNC_LEVEL = 2'd1;

   typedef struct packed {
      logic signed [23:0] unary_cost;
      logic signed [23:0] msg_a;
      logic signed [23:0] msg_b;
      logic signed [23:0] msg_c;
      logic signed [23:0] msg_back;
      logic [15:0]        wt_a;
      logic [15:0]        wt_b;
      logic [15:0]        wt_c;
      logic [15:0]        wt_back;
      logic               last_label;
   } req_type;

   typedef struct packed {
      logic signed [23:0] out_value;
      logic               out_last;
   } rsp_type;

   typedef struct packed {
      logic signed [23:0] partial;
      logic [15:0]        wt_back;
      logic               last;
   } entry_type;

   function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
      logic signed [23:0] r;
      if (v > 32'sd8388607) begin
         r = POS_MAX;
      end else if (v < -32'sd8388608) begin
         r = NEG_MIN;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

[rtl/trw_l1_message_update_top.sv]
// a message passes the front stage, the queue, the radix-2 step divider, the STEP, TRUNC and
// CLAMP setup states and a forward and a backward relax pass before its first item goes out
// the back handles one message at a time, using a store with one write and one read port
// and the radix-2 divider; the front takes items while the back works, until the queue is full
// reset: synchronous active high, clears control and loads gain 256 and truncation 512
`include "trw_l1_message_update_top_macros.svh"

module trw_l1_message_update_top import trwl1_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata
);

   logic [15:0] gain_ff, trunc_ff;
   logic        q_push, q_full, q_pop, q_not_empty;
   entry_type   q_in, q_out;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= 16'd256;
         trunc_ff <= 16'd512;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SMOOTH_GAIN: gain_ff  <= csr_wdata;
            CSR_TRUNC_LEVEL: trunc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   trwl1_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_entry   (q_in)
   );

   trwl1_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_out)
   );

   trwl1_back u_back (
      .clock       (clock),
      .reset       (reset),
      .smooth_gain (gain_ff),
      .trunc_level (trunc_ff),
      .q_not_empty (q_not_empty),
      .q_data      (q_out),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   `TRWL1_ASSERT_ALWAYS(a_top_csr_ready, clock, csr_ready)

endmodule

[rtl/trwl1_front.sv]
`include "trw_l1_message_update_top_macros.svh"

module trwl1_front import trwl1_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_stall,
   input  req_type   req_data,
   input  logic      q_full,
   output logic      q_push,
   output entry_type q_entry
);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [15:0]        wa_ff, wb_ff, wc_ff, wk_ff;
   logic [15:0]        wa, wb, wc, wk;
   logic               s1_valid_ff;
   logic signed [40:0] pa_ff, pb_ff, pc_ff, pk_ff;
   logic signed [23:0] un_ff;
   logic [15:0]        wk_s1_ff;
   logic               last_s1_ff;
   logic               first, accept, ends;
   logic signed [16:0] fk;
   logic signed [43:0] sum;
   logic signed [28:0] rnd;
   logic signed [31:0] tot;

   assign req_stall = s1_valid_ff && q_full;
   assign accept    = req_valid && !req_stall;
   assign first     = (cnt_ff == '0);
   assign wa = first ? req_data.wt_a    : wa_ff;
   assign wb = first ? req_data.wt_b    : wb_ff;
   assign wc = first ? req_data.wt_c    : wc_ff;
   assign wk = first ? req_data.wt_back : wk_ff;
   assign fk = $signed(17'd32768 - {1'b0, wk});
   assign ends = req_data.last_label || (cnt_ff == CNT_W'(NUM_LABELS - 1));
   assign cnt_in = ends ? '0 : cnt_ff + 1'b1;

   assign sum = 44'(pa_ff) + 44'(pb_ff) + 44'(pc_ff) - 44'(pk_ff);
   assign rnd = 29'((sum + 44'sd16384) >>> 15);
   assign tot = 32'(rnd) + 32'(un_ff);

   assign q_push  = s1_valid_ff && !q_full;
   assign q_entry = '{partial: sat24(tot), wt_back: wk_s1_ff, last: last_s1_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff      <= '0;
         s1_valid_ff <= 1'b0;
         wa_ff <= '0; wb_ff <= '0; wc_ff <= '0; wk_ff <= '0;
      end else begin
         if (q_push && !accept) begin
            s1_valid_ff <= 1'b0;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
            cnt_ff      <= cnt_in;
            wa_ff <= wa; wb_ff <= wb; wc_ff <= wc; wk_ff <= wk;
            pa_ff <= req_data.msg_a * $signed({1'b0, wa});
            pb_ff <= req_data.msg_b * $signed({1'b0, wb});
            pc_ff <= req_data.msg_c * $signed({1'b0, wc});
            pk_ff <= req_data.msg_back * fk;
            un_ff      <= req_data.unary_cost;
            wk_s1_ff   <= wk;
            last_s1_ff <= ends;
         end
      end
   end

   `TRWL1_ASSERT(a_front_cnt_range, clock, reset, cnt_ff < CNT_W'(NUM_LABELS))
   `TRWL1_ASSERT(a_front_stall_holds, clock, reset, req_stall |-> s1_valid_ff)
   `TRWL1_ASSERT(a_front_no_overflow, clock, reset, q_push |-> !q_full)

endmodule

[rtl/trwl1_queue.sv]
`include "trw_l1_message_update_top_macros.svh"

module trwl1_queue import trwl1_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_data
);

   entry_type          mem [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff, rd_ff;
   logic [QCNT_W-1:0]  cnt_ff;
   logic               do_push, do_pop;

   assign full      = (cnt_ff == QCNT_W'(QDEPTH));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   `TRWL1_ASSERT(a_queue_count, clock, reset, cnt_ff <= QCNT_W'(QDEPTH))
   `TRWL1_ASSERT(a_queue_ptrs, clock, reset,
      (cnt_ff == '0 || cnt_ff == QCNT_W'(QDEPTH)) |-> (wr_ff == rd_ff))

endmodule

[rtl/trwl1_back.sv]
`include "trw_l1_message_update_top_macros.svh"

module trwl1_back import trwl1_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] smooth_gain,
   input  logic [15:0] trunc_level,
   input  logic        q_not_empty,
   input  entry_type   q_data,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data
);

   typedef enum logic [3:0] {
      LOAD, DIV, STEP, TRUNC, CLAMP, FWD_RD, FWD_WR, BWD_RD, BWD_WR, EMIT_RD, EMIT_WR
   } state_type;

   state_type          state_ff;
   logic signed [23:0] mem [NUM_LABELS];
   logic signed [23:0] rd_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [LBL_W-1:0]   idx_ff, last_idx;
   logic signed [23:0] min_ff, prev_ff, clampv_ff, base_ff;
   logic [15:0]        w_ff, div_rem_ff;
   logic [30:0]        div_q_ff;
   logic [4:0]         div_cnt_ff;
   logic [22:0]        step_ff;
   logic [38:0]        prod_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic [16:0]        div_t;
   logic               div_bit;
   logic [15:0]        div_rem_in;
   logic signed [24:0] cand;
   logic signed [23:0] relaxed, relax_in, clip;
   logic [30:0]        tr;
   logic [23:0]        tr_sat;
   logic signed [24:0] clamp_sum;
   logic               out_free;
   logic               mem_we;
   logic [LBL_W-1:0]   mem_wa, mem_ra;
   logic signed [23:0] mem_wd;

   assign last_idx = LBL_W'(cnt_ff - 1'b1);
   assign q_pop    = (state_ff == LOAD) && q_not_empty;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign div_t      = {div_rem_ff, div_q_ff[30]};
   assign div_bit    = (div_t >= {1'b0, w_ff});
   assign div_rem_in = div_bit ? 16'(div_t - {1'b0, w_ff}) : div_t[15:0];

   assign cand    = $signed({prev_ff[23], prev_ff}) + $signed({2'b00, step_ff});
   assign relaxed = (cand < 25'(rd_ff)) ? cand[23:0] : rd_ff;

   assign tr        = prod_ff[38:8];
   assign tr_sat    = (tr > 31'd8388607) ? 24'd8388607 : tr[23:0];
   assign clamp_sum = 25'(min_ff) + $signed({1'b0, tr_sat});
   assign clip      = (rd_ff > clampv_ff) ? clampv_ff : rd_ff;

   always_comb begin
      relax_in = relaxed;
      if (state_ff == FWD_WR && idx_ff == '0) begin
         relax_in = rd_ff;
      end else if (state_ff == BWD_WR && idx_ff == last_idx) begin
         relax_in = rd_ff;
      end
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = idx_ff;
      mem_wd = relax_in;
      mem_ra = idx_ff;
      unique case (state_ff)
         LOAD: begin
            mem_we = q_pop;
            mem_wa = cnt_ff[LBL_W-1:0];
            mem_wd = q_data.partial;
         end
         FWD_WR, BWD_WR: mem_we = 1'b1;
         default: mem_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LOAD;
         cnt_ff       <= '0;
         idx_ff       <= '0;
         min_ff       <= POS_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!rsp_stall && !(state_ff == EMIT_WR && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            LOAD: begin
               if (q_pop) begin
                  cnt_ff <= cnt_ff + 1'b1;
                  if (q_data.partial < min_ff) begin
                     min_ff <= q_data.partial;
                  end
                  if (cnt_ff == '0) begin
                     w_ff <= q_data.wt_back;
                  end
                  if (q_data.last) begin
                     div_rem_ff <= '0;
                     div_q_ff   <= {smooth_gain, 15'd0};
                     div_cnt_ff <= 5'd30;
                     state_ff   <= DIV;
                  end
               end
            end
            DIV: begin
               div_rem_ff <= div_rem_in;
               div_q_ff   <= {div_q_ff[29:0], div_bit};
               div_cnt_ff <= div_cnt_ff - 1'b1;
               if (div_cnt_ff == '0) begin
                  state_ff <= STEP;
               end
            end
            STEP: begin
               if (w_ff == '0 || div_q_ff > 31'd8388607) begin
                  step_ff <= 23'h7FFFFF;
               end else begin
                  step_ff <= div_q_ff[22:0];
               end
               state_ff <= TRUNC;
            end
            TRUNC: begin
               prod_ff  <= trunc_level * step_ff;
               state_ff <= CLAMP;
            end
            CLAMP: begin
               clampv_ff <= (clamp_sum > 25'sd8388607) ? POS_MAX : clamp_sum[23:0];
               idx_ff    <= '0;
               state_ff  <= FWD_RD;
            end
            FWD_RD: state_ff <= FWD_WR;
            FWD_WR: begin
               prev_ff <= relax_in;
               if (idx_ff == last_idx) begin
                  state_ff <= BWD_RD;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= FWD_RD;
               end
            end
            BWD_RD: state_ff <= BWD_WR;
            BWD_WR: begin
               prev_ff <= relax_in;
               if (idx_ff == '0) begin
                  base_ff  <= (relax_in > clampv_ff) ? clampv_ff : relax_in;
                  state_ff <= EMIT_RD;
               end else begin
                  idx_ff   <= idx_ff - 1'b1;
                  state_ff <= BWD_RD;
               end
            end
            EMIT_RD: state_ff <= EMIT_WR;
            EMIT_WR: begin
               if (out_free) begin
                  rsp_valid_ff       <= 1'b1;
                  rsp_ff.out_value   <= sat24(32'(clip) - 32'(base_ff));
                  rsp_ff.out_last    <= (idx_ff == last_idx);
                  if (idx_ff == last_idx) begin
                     cnt_ff   <= '0;
                     idx_ff   <= '0;
                     min_ff   <= POS_MAX;
                     state_ff <= LOAD;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= EMIT_RD;
                  end
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

   `TRWL1_ASSERT(a_back_cnt_range, clock, reset, cnt_ff <= CNT_W'(NUM_LABELS))
   `TRWL1_ASSERT(a_back_div_rem, clock, reset,
      (state_ff == DIV && w_ff != '0) |-> (div_rem_ff < w_ff))
   `TRWL1_ASSERT(a_back_stalled_out, clock, reset,
      (rsp_valid_ff && rsp_stall) |=> rsp_valid_ff && $stable(rsp_ff))

endmodule

[tb/sv/trw_l1_message_update_top_test.sv]
`timescale 1ns / 100ps

module trw_l1_message_update_top_test;
   import trwl1_pkg::*;

   class message_scoreboard;
      logic [15:0] gain;
      logic [15:0] trunc_lvl;
      longint partials[NUM_LABELS];
      logic [15:0] weights[4];
      int count;
      longint low_mark;
      rsp_type pending[$];
      int errors;

      function void clear_state();
         gain = 16'd256;
         trunc_lvl = 16'd512;
         weights = '{default: 16'd0};
         count = 0;
         low_mark = 8388607;
         errors = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [15:0] v);
         if (idx == CSR_SMOOTH_GAIN) gain = v;
         else if (idx == CSR_TRUNC_LEVEL) trunc_lvl = v;
      endfunction

      function longint clip24(longint v);
         if (v > 8388607) return 8388607;
         if (v < -8388608) return -8388608;
         return v;
      endfunction

      function void note_request(req_type r);
         longint acc, p, step, trunc_amt, ceiling, base, c, q;
         rsp_type e;
         if (count == 0) begin
            weights[0] = r.wt_a;
            weights[1] = r.wt_b;
            weights[2] = r.wt_c;
            weights[3] = r.wt_back;
         end
         acc = longint'(r.msg_a) * weights[0] + longint'(r.msg_b) * weights[1]
             + longint'(r.msg_c) * weights[2]
             - longint'(r.msg_back) * (32768 - longint'(weights[3]));
         acc = acc + 16384;
         q = acc >>> 15;
         p = clip24(longint'(r.unary_cost) + q);
         if (count < NUM_LABELS) begin
            partials[count] = p;
            count++;
         end
         if (p < low_mark) low_mark = p;
         if (!(r.last_label || count >= NUM_LABELS)) return;
         if (weights[3] == 0) step = 8388607;
         else begin
            step = (longint'(gain) << 15) / weights[3];
            if (step > 8388607) step = 8388607;
         end
         trunc_amt = (longint'(trunc_lvl) * step) >> 8;
         if (trunc_amt > 8388607) trunc_amt = 8388607;
         ceiling = low_mark + trunc_amt;
         if (ceiling > 8388607) ceiling = 8388607;
         for (int i = 1; i < count; i++) begin
            c = partials[i-1] + step;
            if (c < partials[i]) partials[i] = c;
         end
         for (int i = count - 2; i >= 0; i--) begin
            c = partials[i+1] + step;
            if (c < partials[i]) partials[i] = c;
         end
         for (int i = 0; i < count; i++)
            if (partials[i] > ceiling) partials[i] = ceiling;
         base = partials[0];
         for (int i = 0; i < count; i++) begin
            e.out_value = 24'(clip24(partials[i] - base));
            e.out_last = (i == count - 1);
            pending.push_back(e);
         end
         count = 0;
         low_mark = 8388607;
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t unexpected item: value %0d last %0b", $time, got.out_value,
                     got.out_last);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.out_value !== e.out_value) begin
            $display("%0t out_value mismatch: expected %0d actual %0d", $time, e.out_value,
                     got.out_value);
            errors++;
         end
         if (got.out_last !== e.out_last) begin
            $display("%0t out_last mismatch: expected %0b actual %0b", $time, e.out_last,
                     got.out_last);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_SMOOTH_GAIN;
   logic [15:0] csr_wdata = '0;

   message_scoreboard board;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int cycles = 0;
   localparam int CYCLE_LIMIT = 400000;

   trw_l1_message_update_top i_dut (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic logic [23:0] pick_value();
      case ($urandom_range(5))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom);
         default: return 24'($signed($urandom_range(8000)) - 4000);
      endcase
   endfunction

   function automatic logic [15:0] pick_weight();
      case ($urandom_range(7))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'($urandom);
         default: return 16'($urandom_range(32768));
      endcase
   endfunction

   task automatic send_item(req_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
   endtask

   task automatic send_message(int n, bit extreme, bit force_last);
      req_type r;
      for (int i = 0; i < n; i++) begin
         r.unary_cost = extreme ? (i[0] ? 24'h7FFFFF : 24'h800000) : pick_value();
         r.msg_a = pick_value();
         r.msg_b = pick_value();
         r.msg_c = pick_value();
         r.msg_back = pick_value();
         r.wt_a = pick_weight();
         r.wt_b = pick_weight();
         r.wt_c = pick_weight();
         r.wt_back = pick_weight();
         r.last_label = (i == n - 1) && force_last;
         send_item(r);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending.size() != 0 || board.count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [15:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_reg(idx, v);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      req_type r;
      board = new();
      board.clear_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_message(1, 0, 1);
      send_message(3, 1, 1);
      send_message(16, 0, 0);
      r = '0;
      r.wt_back = 16'd0;
      r.wt_a = 16'hFFFF;
      r.msg_a = 24'h7FFFFF;
      r.msg_back = 24'h800000;
      send_item(r);
      r.last_label = 1'b1;
      send_item(r);
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 60 : 0;
         recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 12 : 0;
         write_reg(CSR_SMOOTH_GAIN, ph == 0 ? 16'd0 : ph == 1 ? 16'hFFFF : 16'($urandom));
         write_reg(CSR_TRUNC_LEVEL, ph == 0 ? 16'hFFFF : ph == 1 ? 16'd0 : 16'($urandom));
         for (int k = 0; k < 67; k += 0) begin
            int n;
            n = $urandom_range(99) < 10 ? 16 : $urandom_range(1, 8);
            send_message(n, $urandom_range(9) == 0, n < 16 || $urandom_range(1));
            k += n;
         end
         drain();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
